// ===== hw/rtl/frws_pkg.sv =====
package frws_pkg;

    // fixed field widths
    localparam int DATA_W  = 32;
    localparam int BYTES_W = 3;
    localparam int LBI_W   = 8;

    // padded stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // per-cycle move command shared by every cell of the row
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/frame_reversing_word_stack_unit.sv =====
// frame reversing word stack
//
// s_* takes one frame of words: tdata carries the word and its byte count,
// tlast marks the final word of the frame. nothing leaves the block until
// that final word is in; then m_* replays the frame newest word first.
// the first beat out carries the final word's byte count, every later one
// WORD_BYTES; m_tlast marks the oldest word. every beat of the frame also
// carries the index of the frame's last byte and the overflow flag.
//
// words live in a row of STACK_DEPTH cells that all shift one place per
// push or pop. the first result is offered the cycle after the final
// word is taken. input is closed while a frame drains.
// a frame longer than STACK_DEPTH keeps only its newest words (the count
// wraps) and raises overflow for that frame.
// reset empties the stack by clearing the push count, and clears overflow.
// a stall on m_tready simply holds the current beat; nothing is lost.
module frame_reversing_word_stack_unit
#(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_BYTES  = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // beat in: [31:0] word_data, [34:32] byte_count, [39:35] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [frws_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic        s_tlast,
    // beat out: [31:0] out_data, [34:32] out_bytes, [42:35] last_byte_index,
    // [47:43] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [frws_pkg::M_TDATA_W-1:0] m_tdata,
    output logic        m_tlast,
    // [0] overflow
    output logic        m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(2 * STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int IW = 16;

    typedef enum logic {ST_FILL, ST_DRAIN} state_t;

    state_t                          state_reg, state_next;
    logic [PW-1:0]                   ptr_reg, ptr_next;
    logic                            ovf_reg, ovf_next;
    logic [CW-1:0]                   remain_reg, remain_next;
    logic                            first_reg, first_next;
    logic [frws_pkg::BYTES_W-1:0]    count_reg, count_next;
    logic [frws_pkg::LBI_W-1:0]      lbi_reg, lbi_next;

    logic                            in_beat;
    logic                            out_beat;
    logic [frws_pkg::DATA_W-1:0]     in_word;
    logic [frws_pkg::BYTES_W-1:0]    in_count;
    logic [AW-1:0]                   addr;
    logic                            ptr_high;
    logic [IW-1:0]                   idx_wide;
    frws_pkg::cell_ctrl_t            ctrl;
    logic [frws_pkg::DATA_W-1:0]     cell_word [STACK_DEPTH];

    assign in_word  = s_tdata[frws_pkg::DATA_W-1:0];
    assign in_count = s_tdata[frws_pkg::DATA_W +: frws_pkg::BYTES_W];

    assign s_tready = (state_reg == ST_FILL);
    assign m_tvalid = (state_reg == ST_DRAIN);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    assign ctrl.push = in_beat;
    assign ctrl.pop  = out_beat;

    // word index is the push count folded into the stack depth
    assign ptr_high = (ptr_reg >= PW'(STACK_DEPTH));
    assign addr     = ptr_high ? AW'(ptr_reg - PW'(STACK_DEPTH)) : AW'(ptr_reg);

    // last byte index of the frame
    generate
        if (WORD_BYTES == 1)
        begin : g_idx_one
            assign idx_wide = IW'(addr);
        end
        else
        begin : g_idx_many
            assign idx_wide = IW'(addr) * IW'(WORD_BYTES) + IW'(in_count) - IW'(1);
        end
    endgenerate

    // row of cells: cell 0 holds the newest word
    generate
        for (genvar i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            logic [frws_pkg::DATA_W-1:0] newer_w;
            logic [frws_pkg::DATA_W-1:0] older_w;
            if (i == 0)
            begin : g_head
                assign newer_w = in_word;
            end
            else
            begin : g_mid_n
                assign newer_w = cell_word[i-1];
            end
            if (i == STACK_DEPTH - 1)
            begin : g_tail
                assign older_w = cell_word[i];
            end
            else
            begin : g_mid_o
                assign older_w = cell_word[i+1];
            end
            frws_cell u_cell
            (
                .clk   (clk),
                .ctrl  (ctrl),
                .newer (newer_w),
                .older (older_w),
                .word  (cell_word[i])
            );
        end
    endgenerate

    // frame sequencing
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        ovf_next    = ovf_reg;
        remain_next = remain_reg;
        first_next  = first_reg;
        count_next  = count_reg;
        lbi_next    = lbi_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_beat)
                begin
                    ovf_next = ovf_reg | ptr_high;
                    if (ptr_reg == PW'(2 * STACK_DEPTH - 1))
                    begin
                        ptr_next = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + PW'(1);
                    end
                    if (s_tlast)
                    begin
                        state_next  = ST_DRAIN;
                        ptr_next    = '0;
                        remain_next = CW'(addr) + CW'(1);
                        first_next  = 1'b1;
                        count_next  = in_count;
                        lbi_next    = idx_wide[frws_pkg::LBI_W-1:0];
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_beat)
                begin
                    first_next  = 1'b0;
                    remain_next = remain_reg - CW'(1);
                    if (remain_reg == CW'(1))
                    begin
                        state_next = ST_FILL;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_FILL;
            ptr_reg    <= '0;
            ovf_reg    <= 1'b0;
            remain_reg <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ptr_reg    <= ptr_next;
            ovf_reg    <= ovf_next;
            remain_reg <= remain_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        lbi_reg   <= lbi_next;
    end

    // output beat from the head cell
    assign m_tdata = {
        {(frws_pkg::M_TDATA_W - frws_pkg::DATA_W - frws_pkg::BYTES_W
          - frws_pkg::LBI_W){1'b0}},
        lbi_reg,
        (first_reg ? count_reg : frws_pkg::BYTES_W'(WORD_BYTES)),
        cell_word[0]
    };
    assign m_tlast = (remain_reg == CW'(1));
    assign m_tuser = ovf_reg;

endmodule

// ===== hw/rtl/frws_cell.sv =====
module frws_cell
(
    input  logic                         clk,
    input  frws_pkg::cell_ctrl_t         ctrl,
    input  logic [frws_pkg::DATA_W-1:0]  newer,
    input  logic [frws_pkg::DATA_W-1:0]  older,
    output logic [frws_pkg::DATA_W-1:0]  word
);

    logic [frws_pkg::DATA_W-1:0] word_reg;
    logic [frws_pkg::DATA_W-1:0] word_next;

    // push moves words one cell deeper, pop moves them one cell up
    always_comb
    begin
        word_next = word_reg;
        if (ctrl.push)
        begin
            word_next = newer;
        end
        else if (ctrl.pop)
        begin
            word_next = older;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== hw/rtl/frws_checker.sv =====
module frws_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [frws_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           m_tuser
);

    // input stays closed while a frame drains
    assert property (@(posedge clk) disable iff (!rst_n) !(m_tvalid && s_tready))
        else $error("input open during drain");

    // final word in starts the drain on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("drain did not start after frame end");

    // frame summary fields hold across the whole drain
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && $stable(m_tdata[42:35]) && $stable(m_tuser)))
        else $error("frame summary changed mid frame");

    // drain ends with the oldest word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("output beat after last word");

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled beat changed");

endmodule

bind frame_reversing_word_stack_unit frws_checker u_frws_checker (.*);
